### rtl/core/sp_pkg.sv
// stream prefetcher package: sizes, codes, controller/datapath command and status types
// no dependencies; imported by every module of the block
package sp_pkg;

  // table and result sizing
  localparam int TABLE_ENTRIES = 8;
  localparam int MAX_DEGREE    = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int GAP_LINES     = 4;

  localparam int DEG_LIM = (MAX_DEGREE < MAX_RESULTS) ? MAX_DEGREE : MAX_RESULTS;
  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int DEG_W   = $clog2(DEG_LIM + 1);
  localparam int CNT_W   = (IDX_W > DEG_W) ? IDX_W : DEG_W;

  // field widths
  localparam int ADDR_W     = 64;
  localparam int CONF_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // operating modes
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_NEXT   = 2'd1;
  localparam logic [1:0] MODE_STREAM = 2'd2;

  // stream direction codes
  typedef logic [1:0] dir_t;
  localparam dir_t DIR_ZERO = 2'b00;
  localparam dir_t DIR_POS  = 2'b01;
  localparam dir_t DIR_NEG  = 2'b11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_SHIFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONF_THR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CONF_MAX   = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             prep;
    logic             train_step;
    logic             alloc;
    logic             init_next;
    logic             init_stream;
    logic             step;
    logic             flush;
    logic [IDX_W-1:0] idx;
  } sp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             mode_next;
    logic             mode_stream;
    logic             deg_zero;
    logic [DEG_W-1:0] deg;
    logic             hit;
    logic             found;
    logic             dir_zero;
  } sp_status_t;

endpackage

### rtl/core/sp_ctrl.sv
// stream prefetcher controller: sequences load, table training, search and issue
// depends on sp_pkg (command and status types)
module sp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sp_pkg::sp_status_t status,
  output sp_pkg::sp_cmd_t    cmd
);
  import sp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_ROUTE  = 3'd2;
  localparam logic [2:0] S_TRAIN  = 3'd3;
  localparam logic [2:0] S_ALLOC  = 3'd4;
  localparam logic [2:0] S_FIND   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;
  localparam logic [2:0] S_FLUSH  = 3'd7;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(TABLE_ENTRIES - 1);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cnt_at_deg;

  assign busy       = (state_r != S_IDLE);
  assign cnt_at_deg = (cnt_r == CNT_W'(status.deg));

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = cnt_r[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.prep  = 1'b1;
        state_nxt = S_ROUTE;
      end
      S_ROUTE: begin
        cnt_nxt = '0;
        if (status.mode_stream) begin
          state_nxt = S_TRAIN;
        end else if (status.mode_next && !status.deg_zero) begin
          cmd.init_next = 1'b1;
          cnt_nxt       = CNT_W'(1);
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_TRAIN: begin
        cmd.train_step = 1'b1;
        if (status.hit) begin
          cnt_nxt   = '0;
          state_nxt = S_FIND;
        end else if (cnt_r == LAST_IDX) begin
          state_nxt = S_ALLOC;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_FIND;
      end
      S_FIND: begin
        if (status.found) begin
          if (!status.dir_zero && !status.deg_zero) begin
            cmd.init_stream = 1'b1;
            cnt_nxt         = CNT_W'(1);
            state_nxt       = S_EMIT;
          end else begin
            state_nxt = S_FLUSH;
          end
        end else if (cnt_r == LAST_IDX) begin
          state_nxt = S_FLUSH;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_EMIT: begin
        cmd.step = 1'b1;
        if (cnt_at_deg) begin
          state_nxt = S_FLUSH;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### rtl/core/sp_datapath.sv
// stream prefetcher datapath: config registers, stream table, address math, result register
// depends on sp_pkg (widths, codes, command and status types)
module sp_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [sp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [sp_pkg::ADDR_W-1:0]        in_miss_addr,
  input  sp_pkg::sp_cmd_t                  cmd,
  output sp_pkg::sp_status_t               status,
  output logic                             out_valid,
  output logic [sp_pkg::ADDR_W-1:0]        out_prefetch_addr,
  output logic                             out_has_prefetch,
  output logic                             out_last
);
  import sp_pkg::*;

  // configuration
  logic [1:0]        mode_r;
  logic [3:0]        degree_r;
  logic [3:0]        line_shift_r;
  logic [4:0]        page_shift_r;
  logic [CONF_W-1:0] conf_thr_r;
  logic [CONF_W-1:0] conf_max_r;

  // per-item values
  logic [ADDR_W-1:0] addr_r, line_r, lsz_r, neg_lsz_r, line_gap_r, gap2_r, page_mask_r;
  logic [ADDR_W-1:0] prep_lsz, prep_line, prep_gap;

  // stream table
  logic [TABLE_ENTRIES-1:0] ent_valid_r;
  logic [ADDR_W-1:0]        ent_line_r [TABLE_ENTRIES];
  dir_t                     ent_dir_r  [TABLE_ENTRIES];
  logic [CONF_W-1:0]        ent_conf_r [TABLE_ENTRIES];

  // allocation trackers
  logic              free_found_r;
  logic [IDX_W-1:0]  free_idx_r, min_idx_r, slot;
  logic [CONF_W-1:0] min_conf_r;

  // current entry evaluation
  logic              cur_valid;
  logic [ADDR_W-1:0] cur_line, d, e;
  dir_t              cur_dir;
  logic [CONF_W-1:0] cur_conf, conf_bump;
  logic [CONF_W:0]   conf_inc;
  logic              same_pg, is_pos, is_neg, is_near, hit;
  logic [DEG_W-1:0]  deg_sat;

  // issue
  logic [ADDR_W-1:0] pf_r, pend_r;
  logic              dir_neg_r, filter_r, pend_valid_r, cand_ok;

  // output register
  logic              out_valid_r, out_has_r, out_last_r;
  logic [ADDR_W-1:0] out_addr_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_NONE;
      degree_r     <= 4'd2;
      line_shift_r <= 4'd6;
      page_shift_r <= 5'd12;
      conf_thr_r   <= 4'd2;
      conf_max_r   <= 4'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:       mode_r       <= cfg_data[1:0];
        CFG_DEGREE:     degree_r     <= cfg_data[3:0];
        CFG_LINE_SHIFT: line_shift_r <= cfg_data[3:0];
        CFG_PAGE_SHIFT: page_shift_r <= cfg_data[4:0];
        CFG_CONF_THR:   conf_thr_r   <= cfg_data[CONF_W-1:0];
        CFG_CONF_MAX:   conf_max_r   <= cfg_data[CONF_W-1:0];
        default: ;
      endcase
    end
  end

  // degree clamp
  always_comb begin
    if (int'(degree_r) > DEG_LIM) begin
      deg_sat = DEG_W'(DEG_LIM);
    end else begin
      deg_sat = DEG_W'(degree_r);
    end
  end

  // line size, line address and gap window
  assign prep_lsz  = ADDR_W'(1) << line_shift_r;
  assign prep_line = addr_r & ({ADDR_W{1'b1}} << line_shift_r);
  assign prep_gap  = prep_lsz * ADDR_W'(GAP_LINES);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= in_miss_addr;
    end
    if (cmd.prep) begin
      line_r      <= prep_line;
      lsz_r       <= prep_lsz;
      neg_lsz_r   <= ADDR_W'(0) - prep_lsz;
      line_gap_r  <= prep_line + prep_gap;
      gap2_r      <= prep_gap + prep_gap;
      page_mask_r <= {ADDR_W{1'b1}} << page_shift_r;
    end
  end

  // read the entry under the scan index
  assign cur_valid = ent_valid_r[cmd.idx];
  assign cur_line  = ent_line_r[cmd.idx];
  assign cur_dir   = ent_dir_r[cmd.idx];
  assign cur_conf  = ent_conf_r[cmd.idx];

  // delta tests against the miss line
  assign same_pg = cur_valid && (((cur_line ^ addr_r) & page_mask_r) == '0);
  assign d       = line_r - cur_line;
  assign e       = line_gap_r - cur_line;
  assign is_pos  = (d == lsz_r) && (cur_dir != DIR_NEG);
  assign is_neg  = (d == neg_lsz_r) && (cur_dir != DIR_POS);
  assign is_near = (e <= gap2_r);
  assign hit     = same_pg && (is_pos || is_neg || is_near);

  // saturating confidence increment
  assign conf_inc  = {1'b0, cur_conf} + (CONF_W+1)'(1);
  assign conf_bump = (conf_inc > {1'b0, conf_max_r}) ? conf_max_r : conf_inc[CONF_W-1:0];

  assign slot = free_found_r ? free_idx_r : min_idx_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
    end else if (cmd.train_step && hit && !is_pos && !is_neg && (cur_conf <= CONF_W'(1))) begin
      ent_valid_r[cmd.idx] <= 1'b0;
    end else if (cmd.alloc) begin
      ent_valid_r[slot] <= 1'b1;
    end
  end

  // entry contents: training update or allocation
  always_ff @(posedge clk) begin
    if (cmd.train_step && hit) begin
      if (is_pos) begin
        ent_line_r[cmd.idx] <= line_r;
        ent_dir_r[cmd.idx]  <= DIR_POS;
        ent_conf_r[cmd.idx] <= conf_bump;
      end else if (is_neg) begin
        ent_line_r[cmd.idx] <= line_r;
        ent_dir_r[cmd.idx]  <= DIR_NEG;
        ent_conf_r[cmd.idx] <= conf_bump;
      end else if (cur_conf <= CONF_W'(1)) begin
        ent_conf_r[cmd.idx] <= '0;
      end else begin
        ent_conf_r[cmd.idx] <= cur_conf - CONF_W'(1);
      end
    end else if (cmd.alloc) begin
      ent_line_r[slot] <= line_r;
      ent_dir_r[slot]  <= DIR_ZERO;
      ent_conf_r[slot] <= CONF_W'(1);
    end
  end

  // first free entry and least confident entry, gathered during the scan
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      min_idx_r    <= '0;
      min_conf_r   <= '1;
    end else if (cmd.train_step) begin
      if (!cur_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmd.idx;
      end
      if (cur_valid && (cur_conf < min_conf_r)) begin
        min_conf_r <= cur_conf;
        min_idx_r  <= cmd.idx;
      end
    end
  end

  // candidate stays on the miss page unless next-line mode
  assign cand_ok = !filter_r || (((pf_r ^ addr_r) & page_mask_r) == '0);

  // prefetch walk with one pending item so the final one can be marked
  always_ff @(posedge clk) begin
    if (cmd.init_next) begin
      pf_r      <= line_r + lsz_r;
      dir_neg_r <= 1'b0;
      filter_r  <= 1'b0;
    end else if (cmd.init_stream) begin
      pf_r      <= line_r + ((cur_dir == DIR_NEG) ? neg_lsz_r : lsz_r);
      dir_neg_r <= (cur_dir == DIR_NEG);
      filter_r  <= 1'b1;
    end else if (cmd.step) begin
      pf_r <= pf_r + (dir_neg_r ? neg_lsz_r : lsz_r);
    end
    if (cmd.step && cand_ok) begin
      pend_r <= pf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.load) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.step && cand_ok) begin
      pend_valid_r <= 1'b1;
    end
  end

  // result register, one cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.flush || (cmd.step && cand_ok && pend_valid_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush) begin
      out_addr_r <= pend_valid_r ? pend_r : '0;
      out_has_r  <= pend_valid_r;
      out_last_r <= 1'b1;
    end else if (cmd.step && cand_ok && pend_valid_r) begin
      out_addr_r <= pend_r;
      out_has_r  <= 1'b1;
      out_last_r <= 1'b0;
    end
  end

  // status to controller
  always_comb begin
    status             = '0;
    status.mode_next   = (mode_r == MODE_NEXT);
    status.mode_stream = (mode_r == MODE_STREAM);
    status.deg         = deg_sat;
    status.deg_zero    = (deg_sat == '0);
    status.hit         = hit;
    status.found       = same_pg && (cur_conf >= conf_thr_r);
    status.dir_zero    = (cur_dir == DIR_ZERO);
  end

  assign out_valid         = out_valid_r;
  assign out_prefetch_addr = out_addr_r;
  assign out_has_prefetch  = out_has_r;
  assign out_last          = out_last_r;

endmodule

### rtl/core/stream_prefetcher_unit.sv
// stream prefetcher top level: controller plus datapath
// depends on sp_pkg, sp_ctrl, sp_datapath
//
// One miss address is taken per command (start while busy is low) and answered with one
// or more prefetch line addresses, one per out_valid strobe, the final one flagged by
// out_last; an empty answer is a single strobe with out_has_prefetch low. The receiver
// cannot stall, so every strobed item must be captured in its cycle. An item keeps the
// block busy through the decide, route and flush states, with degree emit steps added
// in next-line mode; stream mode adds a training scan, an allocation when nothing hits,
// a find scan and the emit steps. Results leave through a registered output, at most
// one per cycle, and the final item (or the empty answer) is strobed in the first cycle
// in which busy is low. The time an item takes is set by the table being scanned one
// entry per cycle through a single read port, once to train and once to find an issuing
// stream, and by one address adder stepping out the prefetch lines. Configuration writes
// are always accepted (cfg_ready is tied high) and must be made while busy is low.
module stream_prefetcher_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [sp_pkg::ADDR_W-1:0]     in_miss_addr,
  output logic                          out_valid,
  output logic [sp_pkg::ADDR_W-1:0]     out_prefetch_addr,
  output logic                          out_has_prefetch,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sp_pkg::*;

  sp_cmd_t    cmd;
  sp_status_t status;

  assign cfg_ready = 1'b1;

  // sequencing
  sp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // table, address math and result register
  sp_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_miss_addr      (in_miss_addr),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_prefetch_addr (out_prefetch_addr),
    .out_has_prefetch  (out_has_prefetch),
    .out_last          (out_last)
  );

endmodule

### rtl/core/sp_checker.sv
// stream prefetcher port checker and its bind to the top level
// depends on sp_pkg and stream_prefetcher_unit
module sp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [sp_pkg::ADDR_W-1:0] out_prefetch_addr,
  input logic                      out_has_prefetch,
  input logic                      out_last
);
  import sp_pkg::*;

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // an empty answer is always the final item and carries a zero address
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_prefetch) |-> (out_last && (out_prefetch_addr == '0)))
    else $error("empty answer not marked last or address not zero");

  // no item follows directly after the final one
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("item strobed right after a final item");

  // items only come out of work that was in progress
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("item strobed without an item in progress");

endmodule

bind stream_prefetcher_unit sp_checker u_sp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_prefetch_addr (out_prefetch_addr),
  .out_has_prefetch  (out_has_prefetch),
  .out_last          (out_last)
);

### verif/tb_top.sv
`timescale 1ns / 100ps
// testbench for stream_prefetcher_unit: directed and random miss items, results checked
// against a behavioral stream-table predictor; depends on sp_pkg and the unit's RTL
module tb_top;
  import sp_pkg::*;

  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 64;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int STREAMS       = 4;
  localparam int PHASES        = 6;
  localparam int PHASE_MISSES  = 16;

  // mode code with no function of its own, register indexes past the list
  localparam logic [1:0]           MODE_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic [ADDR_W-1:0]     addr;
    int                    gap;
  } request_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic              has_prefetch;
    logic              last;
  } prefetch_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ADDR_W-1:0]     in_miss_addr = '0;
  logic                  out_valid;
  logic [ADDR_W-1:0]     out_prefetch_addr;
  logic                  out_has_prefetch;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  request_t  pending_requests[$];
  prefetch_t due_prefetches[$];
  prefetch_t due_head;
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        gap_count = 0;
  int        idle_count = 0;
  bit        burst = 1'b0;
  int        plan_line_shift = 6;
  int        plan_page_shift = 12;

  // predictor copy of the registers and the stream table
  logic [1:0]        pm_mode;
  logic [3:0]        pm_degree;
  logic [3:0]        pm_line_shift;
  logic [4:0]        pm_page_shift;
  logic [3:0]        pm_conf_thr;
  logic [3:0]        pm_conf_max;
  bit                st_valid[TABLE_ENTRIES];
  logic [ADDR_W-1:0] st_line[TABLE_ENTRIES];
  dir_t              st_dir[TABLE_ENTRIES];
  logic [CONF_W-1:0] st_conf[TABLE_ENTRIES];

  stream_prefetcher_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_miss_addr      (in_miss_addr),
    .out_valid         (out_valid),
    .out_prefetch_addr (out_prefetch_addr),
    .out_has_prefetch  (out_has_prefetch),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // trains the table on one miss, then lists the prefetch lines it answers with
  function automatic void predict_prefetches(logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] lsz, gap, line, page, delta, mag, pf;
    logic [ADDR_W-1:0] lines[$];
    logic [CONF_W:0]   raised;
    int                deg, slot, i, j;
    bit                taken;
    prefetch_t         due;
    lsz  = ADDR_W'(1) << pm_line_shift;
    gap  = ADDR_W'(GAP_LINES) << pm_line_shift;
    line = addr & ~(lsz - ADDR_W'(1));
    page = addr >> pm_page_shift;
    deg  = (pm_degree > DEG_LIM) ? DEG_LIM : int'(pm_degree);
    if (pm_mode == MODE_NEXT) begin
      for (j = 1; j <= deg; j++)
        lines.insert(lines.size(), line + ADDR_W'(j) * lsz);
    end else if (pm_mode == MODE_STREAM) begin
      // first same-page entry that the miss extends or lands near takes it
      taken = 1'b0;
      for (i = 0; i < TABLE_ENTRIES && !taken; i++) begin
        if (st_valid[i] && (st_line[i] >> pm_page_shift) == page) begin
          delta = line - st_line[i];
          mag   = delta[ADDR_W-1] ? -delta : delta;
          if ((delta == lsz && st_dir[i] != DIR_NEG) ||
              (delta == -lsz && st_dir[i] != DIR_POS)) begin
            st_line[i] = line;
            st_dir[i]  = (delta == lsz) ? DIR_POS : DIR_NEG;
            raised     = {1'b0, st_conf[i]} + 1'b1;
            st_conf[i] = (raised > {1'b0, pm_conf_max}) ? pm_conf_max : raised[CONF_W-1:0];
            taken      = 1'b1;
          end else if (mag <= gap) begin
            if (st_conf[i] <= 1) begin
              st_conf[i]  = '0;
              st_valid[i] = 1'b0;
            end else begin
              st_conf[i] = st_conf[i] - 1'b1;
            end
            taken = 1'b1;
          end
        end
      end
      // otherwise allocate a free entry, or replace the least confident one
      if (!taken) begin
        slot = -1;
        for (i = 0; i < TABLE_ENTRIES && slot < 0; i++)
          if (!st_valid[i]) slot = i;
        if (slot < 0) begin
          slot = 0;
          for (i = 1; i < TABLE_ENTRIES; i++)
            if (st_conf[i] < st_conf[slot]) slot = i;
        end
        st_valid[slot] = 1'b1;
        st_line[slot]  = line;
        st_dir[slot]   = DIR_ZERO;
        st_conf[slot]  = 1;
      end
      // first confident same-page entry decides the direction
      for (i = 0; i < TABLE_ENTRIES; i++) begin
        if (st_valid[i] && (st_line[i] >> pm_page_shift) == page &&
            st_conf[i] >= pm_conf_thr) begin
          if (st_dir[i] != DIR_ZERO) begin
            for (j = 1; j <= deg; j++) begin
              pf = (st_dir[i] == DIR_POS) ? line + ADDR_W'(j) * lsz : line - ADDR_W'(j) * lsz;
              if ((pf >> pm_page_shift) == page) lines.insert(lines.size(), pf);
            end
          end
          break;
        end
      end
    end
    if (lines.size() == 0) begin
      due.addr         = '0;
      due.has_prefetch = 1'b0;
      due.last         = 1'b1;
      due_prefetches.insert(due_prefetches.size(), due);
    end else begin
      foreach (lines[k]) begin
        due.addr         = lines[k];
        due.has_prefetch = 1'b1;
        due.last         = (k == lines.size() - 1);
        due_prefetches.insert(due_prefetches.size(), due);
      end
    end
  endfunction

  task automatic queue_register(logic [CFG_IDX_W-1:0] index, int field, int width);
    request_t req;
    int       upper;
    upper        = $urandom;
    req.is_write = 1'b1;
    req.index    = index;
    req.data     = CFG_DATA_W'((upper << width) | field);
    req.addr     = '0;
    req.gap      = 0;
    if (index == CFG_LINE_SHIFT) plan_line_shift = field;
    if (index == CFG_PAGE_SHIFT) plan_page_shift = field;
    pending_requests.insert(pending_requests.size(), req);
  endtask

  task automatic queue_miss(logic [ADDR_W-1:0] addr);
    request_t req;
    req.is_write = 1'b0;
    req.index    = '0;
    req.data     = '0;
    req.addr     = addr;
    req.gap      = burst ? 0 : $urandom_range(0, 15);
    pending_requests.insert(pending_requests.size(), req);
  endtask

  // driver: misses and register writes in queue order, writes only once the unit is quiet
  always @(posedge clk) begin
    logic launch, write;
    request_t req;
    if (!rst_n) begin
      start         <= 1'b0;
      cfg_valid     <= 1'b0;
      gap_count     = 0;
      idle_count    = 0;
      pm_mode       = MODE_NONE;
      pm_degree     = 4'd2;
      pm_line_shift = 4'd6;
      pm_page_shift = 5'd12;
      pm_conf_thr   = 4'd2;
      pm_conf_max   = 4'd4;
      foreach (st_valid[k]) st_valid[k] = 1'b0;
    end else begin
      launch = start;
      write  = 1'b0;
      if (start && !busy) begin
        predict_prefetches(in_miss_addr);
        launch    = 1'b0;
        gap_count = 0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:       pm_mode       = cfg_data[1:0];
          CFG_DEGREE:     pm_degree     = cfg_data[3:0];
          CFG_LINE_SHIFT: pm_line_shift = cfg_data[3:0];
          CFG_PAGE_SHIFT: pm_page_shift = cfg_data[4:0];
          CFG_CONF_THR:   pm_conf_thr   = cfg_data[3:0];
          CFG_CONF_MAX:   pm_conf_max   = cfg_data[3:0];
          default:        ;
        endcase
      end
      if (busy || launch || out_valid || due_prefetches.size() != 0) idle_count = 0;
      else idle_count++;
      // hold a write until taken, else move on to the next request
      if (cfg_valid && !cfg_ready) begin
        write = 1'b1;
      end else if (!launch && pending_requests.size() != 0) begin
        if (pending_requests[0].is_write) begin
          if (idle_count >= SETTLE_CYCLES) begin
            req = pending_requests.pop_front();
            cfg_index <= req.index;
            cfg_data  <= req.data;
            write = 1'b1;
          end
        end else if (gap_count < pending_requests[0].gap) begin
          gap_count++;
        end else begin
          req = pending_requests.pop_front();
          in_miss_addr <= req.addr;
          launch = 1'b1;
        end
      end
      start     <= launch;
      cfg_valid <= write;
    end
  end

  // monitor: every strobed item is compared with the oldest due prefetch
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (due_prefetches.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual addr %h has %b last %b",
                 $time, out_prefetch_addr, out_has_prefetch, out_last);
        mismatch_count++;
      end else begin
        due_head = due_prefetches.pop_front();
        if (out_prefetch_addr !== due_head.addr) begin
          $display("%0t: prefetch_addr expected %h actual %h",
                   $time, due_head.addr, out_prefetch_addr);
          mismatch_count++;
        end
        if (out_has_prefetch !== due_head.has_prefetch) begin
          $display("%0t: has_prefetch expected %b actual %b",
                   $time, due_head.has_prefetch, out_has_prefetch);
          mismatch_count++;
        end
        if (out_last !== due_head.last) begin
          $display("%0t: last expected %b actual %b", $time, due_head.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] cursor[STREAMS];
    int                heading[STREAMS];
    logic [ADDR_W-1:0] lsz, pbytes, base, addr;
    int                phase, n, c, r, mode, thr, cmax, deg, lshift, pshift;

    // mode none, then the unused mode code and writes past the register list
    queue_miss('0);
    queue_miss('1);
    queue_register(CFG_MODE, MODE_SPARE, 2);
    queue_register(CFG_SPARE_A, $urandom_range(0, 255), 8);
    queue_register(CFG_SPARE_B, $urandom_range(0, 255), 8);
    queue_miss(64'h1234);
    // next line with saturated degree wrapping past the top, then degree zero
    queue_register(CFG_MODE, MODE_NEXT, 2);
    queue_register(CFG_DEGREE, 15, 4);
    queue_miss(64'hFFFF_FFFF_FFFF_FFE7);
    queue_register(CFG_DEGREE, 0, 4);
    queue_miss(64'h4000);
    // stream: ascending run, then a confident stream clipped at the page end
    queue_register(CFG_MODE, MODE_STREAM, 2);
    queue_register(CFG_DEGREE, 4, 4);
    queue_miss(64'h1008);
    queue_miss(64'h1050);
    queue_miss(64'h10BC);
    queue_miss(64'h10C0);
    queue_miss(64'h1F84);
    // descending run, then a nearby miss that decays it
    queue_miss(64'h5FC0);
    queue_miss(64'h5F80);
    queue_miss(64'h5F40);
    queue_miss(64'h5FC0);
    // fill the table and force a replacement
    for (n = 1; n <= 6; n++) queue_miss(ADDR_W'(n) << 16);
    // fresh entry at threshold with no direction, zero saturation, decay to invalid
    queue_register(CFG_CONF_THR, 1, 4);
    queue_register(CFG_CONF_MAX, 0, 4);
    queue_miss(64'h9000);
    queue_miss(64'h9040);
    queue_miss(64'h90C0);

    // random phases: mostly stream runs with random content, some noise
    for (phase = 0; phase < PHASES; phase++) begin
      r    = $urandom_range(0, 9);
      mode = (r == 0) ? MODE_NONE : (r == 1) ? MODE_SPARE : (r <= 3) ? MODE_NEXT : MODE_STREAM;
      deg    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      lshift = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 8);
      pshift = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(12, 14);
      thr    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
      cmax   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 6);
      // the first two phases pin the low and high ends
      if (phase == 0) begin
        mode = MODE_STREAM; deg = 8; lshift = 2; pshift = 12; thr = 1; cmax = 1;
      end else if (phase == 1) begin
        mode = MODE_STREAM; deg = 15; lshift = 12; pshift = 21; thr = 15; cmax = 15;
      end
      queue_register(CFG_MODE, mode, 2);
      queue_register(CFG_DEGREE, deg, 4);
      queue_register(CFG_LINE_SHIFT, lshift, 4);
      queue_register(CFG_PAGE_SHIFT, pshift, 5);
      queue_register(CFG_CONF_THR, thr, 4);
      queue_register(CFG_CONF_MAX, cmax, 4);
      lsz    = ADDR_W'(1) << plan_line_shift;
      pbytes = ADDR_W'(1) << plan_page_shift;
      // stream cursors start a few lines from a page edge; the second shares a page
      for (c = 0; c < STREAMS; c++) begin
        heading[c] = $urandom_range(0, 1) ? 1 : -1;
        base = (c == 1) ? cursor[0] : {$urandom, $urandom};
        base = base & ~(pbytes - ADDR_W'(1));
        r    = $urandom_range(0, 12);
        cursor[c] = (heading[c] > 0) ? base + pbytes - ADDR_W'(r + 1) * lsz
                                     : base + ADDR_W'(r) * lsz;
      end
      for (n = 0; n < PHASE_MISSES; n++) begin
        if (n % 8 == 0) burst = ($urandom_range(0, 2) == 0);
        c = $urandom_range(0, STREAMS - 1);
        r = $urandom_range(0, 9);
        if (r == 9) heading[c] = -heading[c];
        if (r == 8) begin
          addr = {$urandom, $urandom};
        end else if (r == 7) begin
          addr = cursor[c] + ADDR_W'($urandom_range(0, 2 * GAP_LINES)) * lsz
                 - ADDR_W'(GAP_LINES) * lsz;
        end else begin
          cursor[c] = (heading[c] > 0) ? cursor[c] + lsz : cursor[c] - lsz;
          addr = cursor[c] | ({$urandom, $urandom} & (lsz - ADDR_W'(1)));
        end
        queue_miss(addr);
      end
    end
    burst = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || start || cfg_valid || busy ||
           due_prefetches.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### stream_prefetcher_unit.f
rtl/core/sp_pkg.sv
rtl/core/sp_ctrl.sv
rtl/core/sp_datapath.sv
rtl/core/stream_prefetcher_unit.sv
rtl/core/sp_checker.sv
verif/tb_top.sv
